### design/ranked_bucket_sorter_assert.svh
// Assertion macros for the ranked bucket sorter.
`ifndef RANKED_BUCKET_SORTER_ASSERT_SVH
`define RANKED_BUCKET_SORTER_ASSERT_SVH
`ifndef SYNTH
`define RBS_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("ranked_bucket_sorter: assertion failed");
`define RBS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("ranked_bucket_sorter: assertion failed");
`else
`define RBS_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define RBS_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

### design/rbs_pkg.sv
// Types, constants and helpers shared by the ranked bucket sorter.
`default_nettype none
package rbs_pkg;

  localparam int MaxElements = 256;
  localparam int ElemAw      = $clog2(MaxElements);
  localparam int ElemCntW    = 9;
  localparam int MaxItems    = 256;
  localparam int ItemAw      = $clog2(MaxItems);
  localparam int CntW        = $clog2(MaxItems + 1);
  localparam int OrdW        = 32;
  localparam int RankW       = $clog2(MaxElements);
  localparam int KeyW        = 9;
  localparam int IdW         = 16;
  localparam int SlotW       = $clog2(MaxElements + 2);
  localparam int SortKeyW    = OrdW + 2;
  localparam int CfgIdxW     = 3;
  localparam int CfgDataW    = 9;

  localparam logic [SlotW-1:0] SlotSubFirst = '0;
  localparam logic [SlotW-1:0] SlotSubLast  = SlotW'(MaxElements + 1);

  // element classes in ascending order
  localparam logic [1:0] ClsAbsent  = 2'd0;
  localparam logic [1:0] ClsNullLow = 2'd1;
  localparam logic [1:0] ClsNormal  = 2'd2;
  localparam logic [1:0] ClsNullTop = 2'd3;

  typedef enum logic [1:0] {
    CmdLoad  = 2'd0,
    CmdAdd   = 2'd1,
    CmdFetch = 2'd2,
    CmdNone  = 2'd3
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgAscending  = 3'd0,
    CfgNullsOnTop = 3'd1,
    CfgSubFirst   = 3'd2,
    CfgNullIdx    = 3'd3,
    CfgElemCount  = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    TopIdle,
    TopPrep,
    TopRank,
    TopScan,
    TopOut
  } top_state_e;

  typedef enum logic {
    RkIdle,
    RkSweep
  } rk_state_e;

  typedef enum logic [2:0] {
    ScIdle,
    ScCount,
    ScSelect,
    ScRead,
    ScDone
  } sc_state_e;

  typedef struct packed {
    logic                en;
    logic [ElemAw-1:0]   idx;
    logic [OrdW-1:0]     ord;
    logic                present;
  } elem_wr_t;

  typedef struct packed {
    logic                en;
    logic [ItemAw-1:0]   idx;
    logic [IdW-1:0]      id;
    logic [KeyW-1:0]     key;
  } item_wr_t;

  typedef struct packed {
    logic                start;
    logic                nulls_on_top;
    logic [KeyW-1:0]     null_idx;
    logic [ElemCntW-1:0] elem_count;
  } rank_req_t;

  typedef struct packed {
    logic                start;
    logic                asc;
    logic                subfirst;
    logic [CntW-1:0]     total;
    logic [CntW-1:0]     pos;
  } scan_req_t;

  function automatic logic [SlotW-1:0] slot_of(input logic [KeyW-1:0] key,
                                               input logic [RankW-1:0] rank,
                                               input logic asc,
                                               input logic subfirst);
    logic [SlotW-1:0] s;
    if (key[KeyW-1]) begin
      s = subfirst ? SlotSubFirst : SlotSubLast;
    end else if (asc) begin
      s = SlotW'(rank) + SlotW'(1);
    end else begin
      s = SlotW'(MaxElements) - SlotW'(rank);
    end
    return s;
  endfunction

endpackage
`default_nettype wire

### design/rbs_if.sv
// Channel interfaces of the ranked bucket sorter.
`default_nettype none
interface rbs_in_if;
  import rbs_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [1:0]               command;
  logic [ElemAw-1:0]        element_index;
  logic signed [OrdW-1:0]   element_ordinal;
  logic                     element_present;
  logic [IdW-1:0]           item_id;
  logic signed [KeyW-1:0]   item_key;
  modport source(output valid, command, element_index, element_ordinal, element_present,
                 item_id, item_key, input ready);
  modport sink(input valid, command, element_index, element_ordinal, element_present,
               item_id, item_key, output ready);
endinterface

interface rbs_out_if;
  import rbs_pkg::*;
  logic           valid;
  logic           ready;
  logic [IdW-1:0] sorted_item;
  logic           last_of_run;
  logic           none_left;
  logic           overflow;
  modport source(output valid, sorted_item, last_of_run, none_left, overflow, input ready);
  modport sink(input valid, sorted_item, last_of_run, none_left, overflow, output ready);
endinterface

interface rbs_cfg_if;
  import rbs_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

### design/rbs_ram.sv
// Generic synchronous RAM, one write port and one registered read port.
`default_nettype none
module rbs_ram #(
  parameter int Width = 8,
  parameter int Depth = 256,
  localparam int Aw = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

### design/rbs_ranker.sv
// Element table and dense ranking by repeated min-above-threshold sweeps.
`default_nettype none
module rbs_ranker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  rbs_pkg::elem_wr_t          wr_i,
  input  rbs_pkg::rank_req_t         req_i,
  output logic                       done_o,
  input  logic [rbs_pkg::ElemAw-1:0] rank_raddr_i,
  output logic [rbs_pkg::RankW-1:0]  rank_rdata_o
);
  import rbs_pkg::*;

  logic [MaxElements-1:0] present_q;
  logic [OrdW-1:0]        ord_rdata;

  rk_state_e            state_q, state_d;
  logic [ElemAw:0]      b_q, b_d;
  logic                 v1_q, v1_d;
  logic [ElemAw-1:0]    idx1_q, idx1_d;
  logic                 pres1_q;
  logic                 have_thr_q, have_thr_d;
  logic [SortKeyW-1:0]  thr_q, thr_d;
  logic [RankW-1:0]     r_q, r_d;
  logic                 cand_v_q, cand_v_d;
  logic [SortKeyW-1:0]  cand_q, cand_d;

  logic [ElemCntW-1:0]  n_act;
  logic                 in_range, is_null, take, sweep_end, issue;
  logic [SortKeyW-1:0]  key1, cand_nxt;
  logic                 cand_v_nxt;
  logic                 rank_we;
  logic [RankW-1:0]     rank_wdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= '0;
    end else if (wr_i.en) begin
      present_q[wr_i.idx] <= wr_i.present;
    end
  end

  // store ordinals with the sign bit flipped so unsigned compare orders them
  rbs_ram #(.Width(OrdW), .Depth(MaxElements)) u_ord_ram (
    .clk_i   (clk_i),
    .we_i    (wr_i.en),
    .waddr_i (wr_i.idx),
    .wdata_i ({~wr_i.ord[OrdW-1], wr_i.ord[OrdW-2:0]}),
    .raddr_i (b_q[ElemAw-1:0]),
    .rdata_o (ord_rdata)
  );

  rbs_ram #(.Width(RankW), .Depth(MaxElements)) u_rank_ram (
    .clk_i   (clk_i),
    .we_i    (rank_we),
    .waddr_i (idx1_q),
    .wdata_i (rank_wdata),
    .raddr_i (rank_raddr_i),
    .rdata_o (rank_rdata_o)
  );

  always_comb begin
    n_act = (req_i.elem_count > ElemCntW'(MaxElements)) ? ElemCntW'(MaxElements)
                                                        : req_i.elem_count;
    in_range = ElemCntW'(idx1_q) < n_act;
    is_null  = !req_i.null_idx[KeyW-1] && (req_i.null_idx[KeyW-2:0] == (KeyW-1)'(idx1_q));
    priority if (!pres1_q) begin
      key1 = {ClsAbsent, {OrdW{1'b0}}};
    end else if (is_null) begin
      key1 = {(req_i.nulls_on_top ? ClsNullLow : ClsNullTop), {OrdW{1'b0}}};
    end else begin
      key1 = {ClsNormal, ord_rdata};
    end
    take = (state_q == RkSweep) && v1_q && in_range && (!have_thr_q || key1 > thr_q) &&
           (!cand_v_q || key1 < cand_q);
    cand_v_nxt = cand_v_q | take;
    cand_nxt   = take ? key1 : cand_q;
    // first sweep clears every entry, later sweeps write matching entries
    rank_we    = (state_q == RkSweep) && v1_q && (!have_thr_q || (in_range && key1 == thr_q));
    rank_wdata = have_thr_q ? r_q : '0;
    sweep_end  = v1_q && (idx1_q == ElemAw'(MaxElements - 1));
    issue      = !b_q[ElemAw];
  end

  always_comb begin
    state_d    = state_q;
    b_d        = b_q;
    v1_d       = 1'b0;
    idx1_d     = idx1_q;
    have_thr_d = have_thr_q;
    thr_d      = thr_q;
    r_d        = r_q;
    cand_v_d   = cand_v_q;
    cand_d     = cand_q;
    done_o     = 1'b0;
    unique case (state_q)
      RkIdle: begin
        if (req_i.start) begin
          state_d    = RkSweep;
          b_d        = '0;
          have_thr_d = 1'b0;
          r_d        = '0;
          cand_v_d   = 1'b0;
        end
      end
      RkSweep: begin
        v1_d     = issue;
        idx1_d   = b_q[ElemAw-1:0];
        b_d      = issue ? b_q + 1'b1 : b_q;
        cand_v_d = cand_v_nxt;
        cand_d   = cand_nxt;
        if (sweep_end) begin
          if (cand_v_nxt) begin
            thr_d      = cand_nxt;
            have_thr_d = 1'b1;
            r_d        = have_thr_q ? r_q + 1'b1 : r_q;
            cand_v_d   = 1'b0;
            b_d        = '0;
          end else begin
            state_d = RkIdle;
            done_o  = 1'b1;
          end
        end
      end
      default: state_d = RkIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= RkIdle;
      b_q        <= '0;
      v1_q       <= 1'b0;
      have_thr_q <= 1'b0;
      cand_v_q   <= 1'b0;
      r_q        <= '0;
    end else begin
      state_q    <= state_d;
      b_q        <= b_d;
      v1_q       <= v1_d;
      have_thr_q <= have_thr_d;
      cand_v_q   <= cand_v_d;
      r_q        <= r_d;
    end
  end

  // present bit is registered from the same address as the ordinal read, so both arrive together
  always_ff @(posedge clk_i) begin
    idx1_q  <= idx1_d;
    pres1_q <= present_q[b_q[ElemAw-1:0]];
    thr_q   <= thr_d;
    cand_q  <= cand_d;
  end
endmodule
`default_nettype wire

### design/rbs_bucket_scan.sv
// Item store and search for the item at a given position of the bucket order.
`default_nettype none
module rbs_bucket_scan (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  rbs_pkg::item_wr_t          wr_i,
  input  rbs_pkg::scan_req_t         req_i,
  output logic                       done_o,
  output logic [rbs_pkg::IdW-1:0]    pick_id_o,
  output logic [rbs_pkg::ElemAw-1:0] rank_raddr_o,
  input  logic [rbs_pkg::RankW-1:0]  rank_rdata_i
);
  import rbs_pkg::*;

  logic [KeyW-1:0]   key_rdata;

  sc_state_e         state_q, state_d;
  logic [ItemAw:0]   i_q, i_d;
  logic              v1_q, v1_d, v2_q, v2_d;
  logic [ItemAw-1:0] idx1_q, idx1_d, idx2_q, idx2_d;
  logic [KeyW-1:0]   key2_q, key2_d;
  logic              have_thr_q, have_thr_d;
  logic [SlotW-1:0]  thr_q, thr_d;
  logic              cand_v_q, cand_v_d;
  logic [SlotW-1:0]  cand_q, cand_d;
  logic [CntW-1:0]   base_q, base_d, cnt_q, cnt_d, sel_q, sel_d;
  logic [ItemAw-1:0] pick_q, pick_d;

  logic [SlotW-1:0]  slot;
  logic              eq, take, at_end, issue;
  logic [CntW-1:0]   cnt_nxt, last_idx;
  logic [CntW:0]     upto;

  rbs_ram #(.Width(KeyW), .Depth(MaxItems)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (wr_i.en),
    .waddr_i (wr_i.idx),
    .wdata_i (wr_i.key),
    .raddr_i (i_q[ItemAw-1:0]),
    .rdata_o (key_rdata)
  );

  rbs_ram #(.Width(IdW), .Depth(MaxItems)) u_id_ram (
    .clk_i   (clk_i),
    .we_i    (wr_i.en),
    .waddr_i (wr_i.idx),
    .wdata_i (wr_i.id),
    .raddr_i (pick_q),
    .rdata_o (pick_id_o)
  );

  assign rank_raddr_o = key_rdata[ElemAw-1:0];

  always_comb begin
    slot     = slot_of(key2_q, rank_rdata_i, req_i.asc, req_i.subfirst);
    eq       = v2_q && have_thr_q && (slot == thr_q);
    take     = v2_q && (!have_thr_q || slot > thr_q) && (!cand_v_q || slot < cand_q);
    cnt_nxt  = eq ? cnt_q + 1'b1 : cnt_q;
    last_idx = req_i.total - 1'b1;
    at_end   = v2_q && (CntW'(idx2_q) == last_idx);
    upto     = (CntW + 1)'(base_q) + (CntW + 1)'(cnt_nxt);
    issue    = (CntW'(i_q) < req_i.total);
  end

  always_comb begin
    state_d    = state_q;
    i_d        = i_q;
    v1_d       = 1'b0;
    v2_d       = 1'b0;
    idx1_d     = i_q[ItemAw-1:0];
    idx2_d     = idx1_q;
    key2_d     = key_rdata;
    have_thr_d = have_thr_q;
    thr_d      = thr_q;
    cand_v_d   = cand_v_q;
    cand_d     = cand_q;
    base_d     = base_q;
    cnt_d      = cnt_q;
    sel_d      = sel_q;
    pick_d     = pick_q;
    done_o     = 1'b0;
    unique case (state_q)
      ScIdle: begin
        if (req_i.start) begin
          i_d        = '0;
          have_thr_d = 1'b0;
          cand_v_d   = 1'b0;
          base_d     = '0;
          cnt_d      = '0;
          if (req_i.total == CntW'(1)) begin
            pick_d  = '0;
            state_d = ScRead;
          end else begin
            state_d = ScCount;
          end
        end
      end
      ScCount: begin
        v1_d     = issue;
        v2_d     = v1_q;
        i_d      = issue ? i_q + 1'b1 : i_q;
        cnt_d    = cnt_nxt;
        cand_v_d = cand_v_q | take;
        cand_d   = take ? slot : cand_q;
        if (at_end) begin
          i_d  = '0;
          v1_d = 1'b0;
          v2_d = 1'b0;
          cnt_d = '0;
          if (have_thr_q && upto > (CntW + 1)'(req_i.pos)) begin
            // the wanted position lies in this bucket
            sel_d   = req_i.pos - base_q;
            state_d = ScSelect;
          end else begin
            base_d     = upto[CntW-1:0];
            thr_d      = take ? slot : cand_q;
            have_thr_d = 1'b1;
            cand_v_d   = 1'b0;
          end
        end
      end
      ScSelect: begin
        v1_d = issue;
        v2_d = v1_q;
        i_d  = issue ? i_q + 1'b1 : i_q;
        if (v2_q && slot == thr_q) begin
          if (cnt_q == sel_q) begin
            pick_d  = idx2_q;
            v1_d    = 1'b0;
            v2_d    = 1'b0;
            state_d = ScRead;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
      end
      ScRead: state_d = ScDone;
      ScDone: begin
        done_o  = 1'b1;
        state_d = ScIdle;
      end
      default: state_d = ScIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ScIdle;
      i_q        <= '0;
      v1_q       <= 1'b0;
      v2_q       <= 1'b0;
      have_thr_q <= 1'b0;
      cand_v_q   <= 1'b0;
      base_q     <= '0;
      cnt_q      <= '0;
      sel_q      <= '0;
      pick_q     <= '0;
    end else begin
      state_q    <= state_d;
      i_q        <= i_d;
      v1_q       <= v1_d;
      v2_q       <= v2_d;
      have_thr_q <= have_thr_d;
      cand_v_q   <= cand_v_d;
      base_q     <= base_d;
      cnt_q      <= cnt_d;
      sel_q      <= sel_d;
      pick_q     <= pick_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx1_q <= idx1_d;
    idx2_q <= idx2_d;
    key2_q <= key2_d;
    thr_q  <= thr_d;
    cand_q <= cand_d;
  end
endmodule
`default_nettype wire

### design/ranked_bucket_sorter.sv
// Ranked bucket sorter: loads elements, stores items, emits them sorted by element rank.
//
// Input channel in_i carries one command word: load an element entry, add an item, or
// fetch the next sorted item. Command 3 is dropped.
// A fetch gives one word on out_o; loads and adds give none. The config channel cfg_i is
// always ready and must only be written while the block is idle.
// With two or more items the first fetch also ranks the element table once: (D+1) sweeps
// of the table, D the number of distinct element values. Each fetch then sweeps the item
// store once to find the lowest bucket, once per occupied bucket up to and including the
// wanted one, and once more to select. The sweeps read one memory entry per cycle; this
// memory port sets the rate.
// Reset empties the item store, marks all elements absent, clears the overflow flag and
// the ranks-valid flag, and loads register defaults. A stalled receiver holds the result in
// the output register; loads and adds are still taken, a further fetch waits.
`default_nettype none
`include "ranked_bucket_sorter_assert.svh"
module ranked_bucket_sorter (
  input  logic      clk_i,
  input  logic      rst_ni,
  rbs_in_if.sink    in_i,
  rbs_out_if.source out_o,
  rbs_cfg_if.sink   cfg_i
);
  import rbs_pkg::*;

  logic                asc_q, nulls_top_q, subfirst_q;
  logic [KeyW-1:0]     null_idx_q;
  logic [ElemCntW-1:0] elem_count_q;

  top_state_e        state_q, state_d;
  logic [CntW-1:0]   total_q, total_d, emit_q, emit_d, p_q, p_d;
  logic              ovf_q, ovf_d, ranks_valid_q, ranks_valid_d;
  logic [IdW-1:0]    res_id_q, res_id_d;
  logic              res_last_q, res_last_d, res_none_q, res_none_d;
  logic              out_valid_q, out_valid_d;
  logic [IdW-1:0]    out_id_q;
  logic              out_last_q, out_none_q, out_ovf_q;
  logic              out_load;

  logic              in_fire, cfg_fire;
  cmd_e              cmd;
  logic [ElemCntW-1:0] n_act;
  logic              bad_key, add_ok;

  elem_wr_t          elem_wr;
  item_wr_t          item_wr;
  rank_req_t         rank_req;
  scan_req_t         scan_req;
  logic              rank_done, scan_done;
  logic [IdW-1:0]    pick_id;
  logic [ElemAw-1:0] rank_raddr;
  logic [RankW-1:0]  rank_rdata;

  assign in_i.ready  = (state_q == TopIdle);
  assign cfg_i.ready = 1'b1;
  assign in_fire     = in_i.valid && in_i.ready;
  assign cfg_fire    = cfg_i.valid && cfg_i.ready;
  assign cmd         = cmd_e'(in_i.command);

  always_comb begin
    n_act   = (elem_count_q > ElemCntW'(MaxElements)) ? ElemCntW'(MaxElements) : elem_count_q;
    bad_key = !in_i.item_key[KeyW-1] && (ElemCntW'(in_i.item_key[ElemAw-1:0]) >= n_act);
    add_ok  = !bad_key && (total_q < CntW'(MaxItems));

    elem_wr.en      = in_fire && (cmd == CmdLoad);
    elem_wr.idx     = in_i.element_index;
    elem_wr.ord     = in_i.element_ordinal;
    elem_wr.present = in_i.element_present;

    item_wr.en  = in_fire && (cmd == CmdAdd) && add_ok;
    item_wr.idx = total_q[ItemAw-1:0];
    item_wr.id  = in_i.item_id;
    item_wr.key = in_i.item_key;

    rank_req.nulls_on_top = nulls_top_q;
    rank_req.null_idx     = null_idx_q;
    rank_req.elem_count   = elem_count_q;
    scan_req.asc          = asc_q;
    scan_req.subfirst     = subfirst_q;
    scan_req.total        = total_q;
    scan_req.pos          = p_q;
  end

  rbs_ranker u_ranker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .wr_i         (elem_wr),
    .req_i        (rank_req),
    .done_o       (rank_done),
    .rank_raddr_i (rank_raddr),
    .rank_rdata_o (rank_rdata)
  );

  rbs_bucket_scan u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .wr_i         (item_wr),
    .req_i        (scan_req),
    .done_o       (scan_done),
    .pick_id_o    (pick_id),
    .rank_raddr_o (rank_raddr),
    .rank_rdata_i (rank_rdata)
  );

  always_comb begin
    state_d        = state_q;
    total_d        = total_q;
    emit_d         = emit_q;
    p_d            = p_q;
    ovf_d          = ovf_q;
    ranks_valid_d  = ranks_valid_q;
    res_id_d       = res_id_q;
    res_last_d     = res_last_q;
    res_none_d     = res_none_q;
    rank_req.start = 1'b0;
    scan_req.start = 1'b0;
    out_load       = 1'b0;
    unique case (state_q)
      TopIdle: begin
        if (in_fire) begin
          unique case (cmd)
            CmdAdd: begin
              if (add_ok) begin
                total_d = total_q + 1'b1;
              end else begin
                ovf_d = 1'b1;
              end
            end
            CmdFetch: begin
              p_d     = (emit_q < total_q) ? emit_q : '0;
              state_d = TopPrep;
            end
            CmdLoad, CmdNone: ;
            default: ;
          endcase
        end
      end
      TopPrep: begin
        priority if (total_q == '0) begin
          res_id_d   = '0;
          res_last_d = 1'b0;
          res_none_d = 1'b1;
          state_d    = TopOut;
        end else if (total_q != CntW'(1) && !ranks_valid_q) begin
          rank_req.start = 1'b1;
          state_d        = TopRank;
        end else begin
          scan_req.start = 1'b1;
          state_d        = TopScan;
        end
      end
      TopRank: begin
        if (rank_done) begin
          ranks_valid_d  = 1'b1;
          scan_req.start = 1'b1;
          state_d        = TopScan;
        end
      end
      TopScan: begin
        if (scan_done) begin
          res_id_d   = pick_id;
          res_none_d = 1'b0;
          res_last_d = (p_q + 1'b1 == total_q);
          // end of run: empty the store, keep the ranks
          if (p_q + 1'b1 == total_q) begin
            total_d = '0;
            emit_d  = '0;
          end else begin
            emit_d = p_q + 1'b1;
          end
          state_d = TopOut;
        end
      end
      TopOut: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = TopIdle;
        end
      end
      default: state_d = TopIdle;
    endcase
    out_valid_d = out_load | (out_valid_q & ~out_o.ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= TopIdle;
      total_q       <= '0;
      emit_q        <= '0;
      p_q           <= '0;
      ovf_q         <= 1'b0;
      ranks_valid_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      total_q       <= total_d;
      emit_q        <= emit_d;
      p_q           <= p_d;
      ovf_q         <= ovf_d;
      ranks_valid_q <= ranks_valid_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_id_q   <= res_id_d;
    res_last_q <= res_last_d;
    res_none_q <= res_none_d;
    if (out_load) begin
      out_id_q   <= res_id_q;
      out_last_q <= res_last_q;
      out_none_q <= res_none_q;
      out_ovf_q  <= ovf_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      asc_q        <= 1'b1;
      nulls_top_q  <= 1'b0;
      subfirst_q   <= 1'b0;
      null_idx_q   <= '1;
      elem_count_q <= '0;
    end else if (cfg_fire) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CfgAscending:  asc_q        <= cfg_i.data[0];
        CfgNullsOnTop: nulls_top_q  <= cfg_i.data[0];
        CfgSubFirst:   subfirst_q   <= cfg_i.data[0];
        CfgNullIdx:    null_idx_q   <= cfg_i.data[KeyW-1:0];
        CfgElemCount:  elem_count_q <= cfg_i.data[ElemCntW-1:0];
        default: ;
      endcase
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.sorted_item = out_id_q;
  assign out_o.last_of_run = out_last_q;
  assign out_o.none_left   = out_none_q;
  assign out_o.overflow    = out_ovf_q;

  `RBS_ASSERT_NOW(a_total_bound, clk_i, rst_ni, 1'b1, total_q <= CntW'(MaxItems))
  `RBS_ASSERT_NEXT(a_fetch_prep, clk_i, rst_ni, in_fire && (cmd == CmdFetch), state_q == TopPrep)
  `RBS_ASSERT_NOW(a_scan_ranked, clk_i, rst_ni, state_q == TopScan, ranks_valid_q || (total_q == CntW'(1)))
  `RBS_ASSERT_NOW(a_emit_bound, clk_i, rst_ni, 1'b1, (emit_q < total_q) || (emit_q == '0))
endmodule
`default_nettype wire
